[hw/rtl/lfpd_pkg.sv]
package lfpd_pkg;

  // fixed widths of the control arithmetic
  localparam int GAIN_W  = 8;
  localparam int POS_W   = 12;
  localparam int ERR_W   = 13;
  localparam int DIFF_W  = 14;
  localparam int TOTAL_W = 24;
  localparam int ACC_W   = 34;
  localparam int DRV_W   = 16;

  // reference position for the error, 7.5 in 1/256 units
  localparam logic [POS_W-1:0] MID_POS = 12'd1920;

endpackage

[hw/rtl/lfpd_div.sv]
module lfpd_div #(
  parameter int SUM_BITS = 7,
  parameter int CNT_BITS = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [SUM_BITS-1:0]      index_sum,
  input  logic [CNT_BITS-1:0]      hit_count,
  output logic                     done,
  output logic [SUM_BITS+8-1:0]    quotient
);

  localparam int DW    = SUM_BITS + 8;
  localparam int STEPW = $clog2(DW + 1);

  logic                busy;
  logic [STEPW-1:0]    steps;
  logic [DW-1:0]       dividend;
  logic [CNT_BITS-1:0] rem;
  logic [CNT_BITS:0]   trial;
  logic                fits;

  // one quotient bit per cycle, restoring
  assign trial = {rem, dividend[DW-1]};
  assign fits  = trial >= {1'b0, hit_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        steps    <= STEPW'(DW);
        dividend <= {index_sum, 8'd0};
        rem      <= '0;
        quotient <= '0;
      end else if (busy) begin
        dividend <= dividend << 1;
        if (fits) begin
          rem <= CNT_BITS'(trial - {1'b0, hit_count});
        end else begin
          rem <= trial[CNT_BITS-1:0];
        end
        quotient <= {quotient[DW-2:0], fits};
        steps <= steps - STEPW'(1);
        if (steps == STEPW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[hw/rtl/lfpd_mac.sv]
module lfpd_mac (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic        [lfpd_pkg::GAIN_W-1:0]    gain_p,
  input  logic        [lfpd_pkg::GAIN_W-1:0]    gain_d,
  input  logic        [lfpd_pkg::GAIN_W-1:0]    gain_i,
  input  logic signed [lfpd_pkg::ERR_W-1:0]     err,
  input  logic signed [lfpd_pkg::DIFF_W-1:0]    diff,
  input  logic signed [lfpd_pkg::TOTAL_W-1:0]   total,
  output logic                                  done,
  output logic signed [lfpd_pkg::ACC_W-1:0]     acc
);

  localparam int BITW = $clog2(lfpd_pkg::GAIN_W);

  typedef enum logic [1:0] {PH_P, PH_D, PH_I} phase_t;

  phase_t                              phase;
  logic                                busy;
  logic [BITW-1:0]                     bit_cnt;
  logic [lfpd_pkg::GAIN_W-1:0]         mult;
  logic signed [lfpd_pkg::ACC_W-1:0]   op;

  // shift-add over the gain bits, one gain after the other
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      phase   <= PH_P;
      bit_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        acc     <= '0;
        op      <= lfpd_pkg::ACC_W'(err);
        mult    <= gain_p;
        phase   <= PH_P;
        bit_cnt <= '0;
      end else if (busy) begin
        if (mult[0]) begin
          acc <= acc + op;
        end
        op      <= op <<< 1;
        mult    <= mult >> 1;
        bit_cnt <= bit_cnt + BITW'(1);
        if (bit_cnt == BITW'(lfpd_pkg::GAIN_W - 1)) begin
          case (phase)
            PH_P: begin
              op    <= lfpd_pkg::ACC_W'(diff);
              mult  <= gain_d;
              phase <= PH_D;
            end
            PH_D: begin
              op    <= lfpd_pkg::ACC_W'(total);
              mult  <= gain_i;
              phase <= PH_I;
            end
            default: begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          endcase
        end
      end
    end
  end

endmodule

[hw/rtl/line_follow_pd_controller.sv]
// Line follower loop controller. Converter samples arrive one word at a time on the
// slave stream, SENSORS words to a scan in array order; a sample below the threshold
// register marks its sensor as on the line. Samples are taken only while the sequencer
// is idle; each but the last of a scan just adds to the running sums. The last starts
// the scan-end work: a bit-serial divider forms the centroid, then a shift-add unit
// forms the P, D and I products one gain bit per cycle, as the sequencer steps through
// its divide, update, multiply and drive states (a stop result skips the last two).
// The next scan's samples are still taken while a finished result waits on the master
// stream, and only the closing sample of a scan waits for it. A result carries both
// drives, the position and two flags; once more than settle_scans scans have passed
// since the last restart, an edge condition gives a stop result with zero drives and
// restarts the loop state. Configuration is written through a plain write port and
// must be changed only while the block is idle.
module line_follow_pd_controller #(
  parameter int SENSORS     = 13,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // sample stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,   // sample
  // result stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [47:0]                          m_tdata,   // right_drive, left_drive, position
  output logic [1:0]                           m_tuser,   // line_seen, stop
  // configuration writes
  input  logic                                 cfg_wr_en,
  input  logic [2:0]                           cfg_index,
  input  logic [9:0]                           cfg_wr_data
);

  localparam int IDX_BITS = $clog2(SENSORS);
  localparam int CNT_BITS = $clog2(SENSORS + 1);
  localparam int SUM_BITS = $clog2(SENSORS * (SENSORS - 1) / 2 + 1);
  localparam int QW_RAW   = SUM_BITS + 8;
  localparam int QW       = (QW_RAW > lfpd_pkg::POS_W) ? QW_RAW : lfpd_pkg::POS_W;
  localparam int CMP_W    = (SAMPLE_BITS > 10) ? SAMPLE_BITS : 10;
  localparam int PID_W    = lfpd_pkg::ACC_W - 8;
  localparam int WIDE_W   = PID_W + 1;
  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(SENSORS - 1);

  // register indexes
  localparam logic [2:0] REG_THRESHOLD  = 3'd0;
  localparam logic [2:0] REG_GAIN_P     = 3'd1;
  localparam logic [2:0] REG_GAIN_D     = 3'd2;
  localparam logic [2:0] REG_GAIN_I     = 3'd3;
  localparam logic [2:0] REG_BASE_SPEED = 3'd4;
  localparam logic [2:0] REG_EXIT_MODE  = 3'd5;
  localparam logic [2:0] REG_SETTLE     = 3'd6;

  localparam logic [9:0] SCAN_MAX = 10'd1023;
  localparam logic signed [lfpd_pkg::TOTAL_W-1:0] TOTAL_MAX = 24'sh7FFFFF;
  localparam logic signed [lfpd_pkg::TOTAL_W-1:0] TOTAL_MIN = -24'sh800000;

  typedef enum logic [2:0] {ST_IDLE, ST_DIVIDE, ST_UPDATE, ST_MAC, ST_DRIVE} state_t;

  // configuration
  logic [9:0]                  threshold;
  logic [lfpd_pkg::GAIN_W-1:0] gain_p;
  logic [lfpd_pkg::GAIN_W-1:0] gain_d;
  logic [lfpd_pkg::GAIN_W-1:0] gain_i;
  logic [9:0]                  base_speed;
  logic                        exit_mode;
  logic [9:0]                  settle_scans;

  // scan accumulation
  logic [IDX_BITS-1:0]         sensor_index;
  logic [SUM_BITS-1:0]         index_sum;
  logic [CNT_BITS-1:0]         hit_count;
  logic [1:0]                  edge_flags;

  // snapshot of a finished scan
  logic [SUM_BITS-1:0]         scan_sum;
  logic [CNT_BITS-1:0]         scan_cnt;
  logic [1:0]                  scan_edge;

  // loop state
  logic [lfpd_pkg::POS_W-1:0]          held_position;
  logic signed [lfpd_pkg::ERR_W-1:0]   previous_error;
  logic signed [lfpd_pkg::TOTAL_W-1:0] error_total;
  logic [9:0]                          scan_count;
  logic signed [lfpd_pkg::DIFF_W-1:0]  err_diff;

  state_t state;
  logic   div_start;
  logic   div_done;
  logic   mac_start;
  logic   mac_done;
  logic [QW_RAW-1:0]                 quotient;
  logic signed [lfpd_pkg::ACC_W-1:0] acc;

  // result register
  logic signed [lfpd_pkg::DRV_W-1:0] right_drive;
  logic signed [lfpd_pkg::DRV_W-1:0] left_drive;
  logic [lfpd_pkg::POS_W-1:0]        position;
  logic                              line_seen;
  logic                              stop;

  // sample side
  logic [SAMPLE_BITS-1:0] sample;
  logic                   hit;
  logic                   in_accept;
  logic [SUM_BITS-1:0]    sum_next;
  logic [CNT_BITS-1:0]    cnt_next;
  logic [1:0]             edge_next;

  assign sample    = s_tdata[SAMPLE_BITS-1:0];
  assign hit       = CMP_W'(sample) < CMP_W'(threshold);
  // the closing sample of a scan waits until the result slot is free
  assign s_tready  = (state == ST_IDLE) && !(m_tvalid && (sensor_index == LAST_IDX));
  assign in_accept = s_tvalid && s_tready;

  always_comb begin
    sum_next  = index_sum;
    cnt_next  = hit_count;
    edge_next = edge_flags;
    if (hit) begin
      sum_next = index_sum + SUM_BITS'(sensor_index);
      cnt_next = hit_count + CNT_BITS'(1);
      if (sensor_index == '0) begin
        edge_next[0] = 1'b1;
      end
      if (sensor_index == LAST_IDX) begin
        edge_next[1] = 1'b1;
      end
    end
  end

  // scan end values
  logic [QW-1:0]                        quot_ext;
  logic                                 seen;
  logic [lfpd_pkg::POS_W-1:0]           pos_new;
  logic                                 edge_hit;
  logic                                 exit_now;
  logic signed [lfpd_pkg::ERR_W-1:0]    err_new;
  logic signed [lfpd_pkg::TOTAL_W:0]    total_sum;
  logic signed [lfpd_pkg::TOTAL_W-1:0]  total_next;

  assign quot_ext = QW'(quotient);
  assign seen     = scan_cnt != '0;
  assign pos_new  = seen ? quot_ext[lfpd_pkg::POS_W-1:0] : held_position;
  assign edge_hit = exit_mode ? (scan_edge != 2'b00) : (scan_edge == 2'b11);
  assign exit_now = (scan_count > settle_scans) && edge_hit;
  assign err_new  = $signed({1'b0, pos_new}) - $signed({1'b0, lfpd_pkg::MID_POS});
  assign total_sum = (lfpd_pkg::TOTAL_W + 1)'(error_total)
                   + (lfpd_pkg::TOTAL_W + 1)'(err_new);

  // saturating integral
  always_comb begin
    if (total_sum[lfpd_pkg::TOTAL_W] != total_sum[lfpd_pkg::TOTAL_W-1]) begin
      total_next = total_sum[lfpd_pkg::TOTAL_W] ? TOTAL_MIN : TOTAL_MAX;
    end else begin
      total_next = total_sum[lfpd_pkg::TOTAL_W-1:0];
    end
  end

  // pid value, truncated toward zero, and the two clamped drives
  logic signed [lfpd_pkg::ACC_W-1:0] acc_adj;
  logic signed [PID_W-1:0]           pid;
  logic signed [WIDE_W-1:0]          base_wide;
  logic signed [WIDE_W-1:0]          right_wide;
  logic signed [WIDE_W-1:0]          left_wide;

  assign acc_adj    = acc[lfpd_pkg::ACC_W-1] ? acc + lfpd_pkg::ACC_W'(255) : acc;
  assign pid        = acc_adj[lfpd_pkg::ACC_W-1:8];
  assign base_wide  = $signed({{(WIDE_W-10){1'b0}}, base_speed});
  assign right_wide = base_wide - WIDE_W'(pid);
  assign left_wide  = base_wide + WIDE_W'(pid);

  function automatic logic signed [lfpd_pkg::DRV_W-1:0] sat16(
    input logic signed [WIDE_W-1:0] v
  );
    logic signed [lfpd_pkg::DRV_W-1:0] r;
    if (v > WIDE_W'(32767)) begin
      r = 16'sh7FFF;
    end else if (v < -WIDE_W'(32768)) begin
      r = -16'sh8000;
    end else begin
      r = v[lfpd_pkg::DRV_W-1:0];
    end
    return r;
  endfunction

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= 10'd500;
      gain_p       <= 8'd20;
      gain_d       <= 8'd10;
      gain_i       <= 8'd0;
      base_speed   <= 10'd0;
      exit_mode    <= 1'b0;
      settle_scans <= 10'd400;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_THRESHOLD:  threshold    <= cfg_wr_data;
        REG_GAIN_P:     gain_p       <= cfg_wr_data[7:0];
        REG_GAIN_D:     gain_d       <= cfg_wr_data[7:0];
        REG_GAIN_I:     gain_i       <= cfg_wr_data[7:0];
        REG_BASE_SPEED: base_speed   <= cfg_wr_data;
        REG_EXIT_MODE:  exit_mode    <= cfg_wr_data[0];
        REG_SETTLE:     settle_scans <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // sequencer, loop state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      div_start      <= 1'b0;
      mac_start      <= 1'b0;
      m_tvalid       <= 1'b0;
      sensor_index   <= '0;
      index_sum      <= '0;
      hit_count      <= '0;
      edge_flags     <= 2'b00;
      held_position  <= lfpd_pkg::MID_POS;
      previous_error <= '0;
      error_total    <= '0;
      scan_count     <= '0;
    end else begin
      div_start <= 1'b0;
      mac_start <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            if (sensor_index == LAST_IDX) begin
              // close the scan and start the centroid divide
              scan_sum     <= sum_next;
              scan_cnt     <= cnt_next;
              scan_edge    <= edge_next;
              sensor_index <= '0;
              index_sum    <= '0;
              hit_count    <= '0;
              edge_flags   <= 2'b00;
              div_start    <= 1'b1;
              state        <= ST_DIVIDE;
            end else begin
              sensor_index <= sensor_index + IDX_BITS'(1);
              index_sum    <= sum_next;
              hit_count    <= cnt_next;
              edge_flags   <= edge_next;
            end
          end
        end
        ST_DIVIDE: begin
          if (div_done) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          position  <= pos_new;
          line_seen <= seen;
          if (exit_now) begin
            // stop word: drives zero, loop state restarts
            right_drive    <= '0;
            left_drive     <= '0;
            stop           <= 1'b1;
            m_tvalid       <= 1'b1;
            held_position  <= lfpd_pkg::MID_POS;
            previous_error <= '0;
            error_total    <= '0;
            scan_count     <= '0;
            state          <= ST_IDLE;
          end else begin
            if (scan_count < SCAN_MAX) begin
              scan_count <= scan_count + 10'd1;
            end
            held_position  <= pos_new;
            err_diff       <= lfpd_pkg::DIFF_W'(err_new) - lfpd_pkg::DIFF_W'(previous_error);
            previous_error <= err_new;
            error_total    <= total_next;
            mac_start      <= 1'b1;
            state          <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (mac_done) begin
            state <= ST_DRIVE;
          end
        end
        ST_DRIVE: begin
          right_drive <= sat16(right_wide);
          left_drive  <= sat16(left_wide);
          stop        <= 1'b0;
          m_tvalid    <= 1'b1;
          state       <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // centroid divide
  lfpd_div #(
    .SUM_BITS (SUM_BITS),
    .CNT_BITS (CNT_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .index_sum (scan_sum),
    .hit_count (scan_cnt),
    .done      (div_done),
    .quotient  (quotient)
  );

  // p, d and i products; operands are registered together with start
  lfpd_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .start  (mac_start),
    .gain_p (gain_p),
    .gain_d (gain_d),
    .gain_i (gain_i),
    .err    (previous_error),
    .diff   (err_diff),
    .total  (error_total),
    .done   (mac_done),
    .acc    (acc)
  );

  assign m_tdata = {4'd0, position, left_drive, right_drive};
  assign m_tuser = {stop, line_seen};

  // checks
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    sensor_index <= LAST_IDX)
    else $error("sensor index past the last sensor");

  a_scan_end_slot: assert property (@(posedge clk) disable iff (rst)
    (in_accept && sensor_index == LAST_IDX) |-> !m_tvalid)
    else $error("scan closed while a result word is still waiting");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIVIDE)
    else $error("divider finished outside the divide step");

  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && stop) |-> (right_drive == '0 && left_drive == '0))
    else $error("stop word with non-zero drive");

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    ($rose(m_tvalid) && stop) |-> (scan_count == '0 && error_total == '0))
    else $error("loop state not cleared on stop");

endmodule

[dv/tb_line_follow_pd_controller.sv]
`timescale 1ns / 100ps

module tb_line_follow_pd_controller;

  import lfpd_pkg::*;

  localparam int SENSORS     = 13;
  localparam int SAMPLE_BITS = 10;
  localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;

  // headroom after the last result before the loop is reconfigured
  localparam int SCAN_END_WAIT = 64;
  localparam int MAX_WAIT      = 14;
  localparam int MAX_REPORTS   = 10;

  localparam logic [9:0] SAMPLE_MAX = 10'h3FF;
  localparam int         TOTAL_HI   = 8388607;
  localparam int         TOTAL_LO   = -8388608;
  localparam int         SCANS_SAT  = 1023;

  // register map of the write port
  typedef enum logic [2:0] {
    REG_THRESHOLD    = 3'd0,
    REG_GAIN_P       = 3'd1,
    REG_GAIN_D       = 3'd2,
    REG_GAIN_I       = 3'd3,
    REG_BASE_SPEED   = 3'd4,
    REG_EXIT_MODE    = 3'd5,
    REG_SETTLE_SCANS = 3'd6,
    REG_UNUSED       = 3'd7
  } cfg_reg_e;

  // exit conditions on the first and last sensors
  localparam logic [9:0] EXIT_BOTH   = 10'd0;
  localparam logic [9:0] EXIT_EITHER = 10'd1;

  // sensor masks, bit i set means sensor i sees the line
  localparam logic [SENSORS-1:0] MASK_NONE  = '0;
  localparam logic [SENSORS-1:0] MASK_ALL   = '1;
  localparam logic [SENSORS-1:0] MASK_FIRST = 13'h0001;
  localparam logic [SENSORS-1:0] MASK_LAST  = 13'h1000;
  localparam logic [SENSORS-1:0] MASK_EDGES = 13'h1001;

  // one drive update as it leaves the block
  typedef struct packed {
    logic signed [DRV_W-1:0] right_drive;
    logic signed [DRV_W-1:0] left_drive;
    logic [POS_W-1:0]        position;
    logic                    line_seen;
    logic                    stop;
  } drive_update_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata  = '0;    // sample
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [47:0]        m_tdata;          // right_drive, left_drive, position
  logic [1:0]         m_tuser;          // line_seen, stop
  logic               cfg_wr_en   = 1'b0;
  logic [2:0]         cfg_index   = '0;
  logic [9:0]         cfg_wr_data = '0;

  line_follow_pd_controller #(
    .SENSORS     (SENSORS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // loop model: its own copy of the registers and of the controller state
  // --------------------------------------------------------------------------
  logic [9:0] thr;
  logic [7:0] kp, kd, ki;
  logic [9:0] base;
  logic       exit_either;
  logic [9:0] settle;

  int         sensor;       // position of the next sample within the scan
  int         idx_sum;
  int         hits;
  logic [1:0] edges;        // bit0 first sensor, bit1 last sensor
  int         hold_pos;
  int         prev_err;
  int         err_total;
  int         scans_done;

  drive_update_t pending_drives[$];   // updates owed by the block, oldest first

  int mismatch_count = 0;
  int src_gap_max    = 0;
  int sink_stall_max = 0;
  bit took_result    = 1'b0;
  int ready_wait     = 0;

  function automatic void clear_loop();
    hold_pos   = int'(MID_POS);
    prev_err   = 0;
    err_total  = 0;
    scans_done = 0;
  endfunction

  function automatic void reset_model();
    thr         = 10'd500;
    kp          = 8'd20;
    kd          = 8'd10;
    ki          = 8'd0;
    base        = 10'd0;
    exit_either = 1'b0;
    settle      = 10'd400;
    sensor      = 0;
    idx_sum     = 0;
    hits        = 0;
    edges       = 2'b00;
    clear_loop();
  endfunction

  function automatic void apply_reg(cfg_reg_e idx, logic [9:0] val);
    case (idx)
      REG_THRESHOLD:    thr = val;
      REG_GAIN_P:       kp = val[7:0];
      REG_GAIN_D:       kd = val[7:0];
      REG_GAIN_I:       ki = val[7:0];
      REG_BASE_SPEED:   base = val;
      REG_EXIT_MODE:    exit_either = val[0];
      REG_SETTLE_SCANS: settle = val;
      default: ;        // unmapped index, nothing changes
    endcase
  endfunction

  function automatic logic signed [DRV_W-1:0] clamp_drive(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[DRV_W-1:0];
  endfunction

  // advance the loop by one sample; the closing sample of a scan owes an update
  function automatic void track_sample(logic [9:0] smp);
    drive_update_t upd;
    bit     seen, edge_hit;
    int     pos, err;
    longint total, acc, pid;

    if (smp < thr) begin
      idx_sum += sensor;
      hits    += 1;
      if (sensor == 0) edges[0] = 1'b1;
      if (sensor == SENSORS - 1) edges[1] = 1'b1;
    end
    if (sensor < SENSORS - 1) begin
      sensor += 1;
      return;
    end

    // scan end: centroid truncated, or the held one when the line is lost
    seen     = (hits != 0);
    pos      = seen ? (idx_sum * 256) / hits : hold_pos;
    pos      = pos & 12'hFFF;
    edge_hit = exit_either ? (edges != 2'b00) : (edges == 2'b11);
    sensor   = 0;
    idx_sum  = 0;
    hits     = 0;
    edges    = 2'b00;

    upd.position  = pos[POS_W-1:0];
    upd.line_seen = seen;

    if (scans_done > int'(settle) && edge_hit) begin
      clear_loop();
      upd.right_drive = '0;
      upd.left_drive  = '0;
      upd.stop        = 1'b1;
      pending_drives.push_back(upd);
      return;
    end

    if (scans_done < SCANS_SAT) scans_done += 1;
    hold_pos = pos;
    err      = pos - int'(MID_POS);

    // integral first, saturating at 24 bits signed
    total = longint'(err_total) + err;
    if (total > TOTAL_HI) total = TOTAL_HI;
    if (total < TOTAL_LO) total = TOTAL_LO;
    err_total = int'(total);

    acc = longint'(kp) * err + longint'(kd) * (longint'(err) - prev_err)
        + longint'(ki) * err_total;
    pid = acc / 256;    // truncates toward zero
    prev_err = err;

    upd.right_drive = clamp_drive(longint'(base) - pid);
    upd.left_drive  = clamp_drive(longint'(base) + pid);
    upd.stop        = 1'b0;
    pending_drives.push_back(upd);
  endfunction

  // --------------------------------------------------------------------------
  // result side: ready stalls and the scoreboard
  // --------------------------------------------------------------------------
  function automatic int draw_wait(int max_wait);
    return (max_wait == 0) ? 0 : $urandom_range(max_wait, 0);
  endfunction

  // a fresh stall is drawn after each word taken from the result stream
  always @(negedge clk) begin
    if (took_result) begin
      took_result = 1'b0;
      ready_wait  = draw_wait(sink_stall_max);
    end
    if (ready_wait > 0) begin
      m_tready <= 1'b0;
      ready_wait -= 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic void note_mismatch(string what, drive_update_t want,
                                        drive_update_t got);
    mismatch_count += 1;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t mismatch (%s): expected R=%0d L=%0d pos=%0d seen=%0b stop=%0b,",
               $realtime, what, want.right_drive, want.left_drive, want.position,
               want.line_seen, want.stop,
               " got R=%0d L=%0d pos=%0d seen=%0b stop=%0b",
               got.right_drive, got.left_drive, got.position, got.line_seen, got.stop);
  endfunction

  always @(posedge clk) begin : check_results
    drive_update_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      took_result     = 1'b1;
      got.right_drive = m_tdata[15:0];
      got.left_drive  = m_tdata[31:16];
      got.position    = m_tdata[43:32];
      got.line_seen   = m_tuser[0];
      got.stop        = m_tuser[1];
      if (pending_drives.size() == 0) begin
        want = '0;
        note_mismatch("unexpected word", want, got);
      end else begin
        want = pending_drives.pop_front();
        if (got.right_drive !== want.right_drive) note_mismatch("right_drive", want, got);
        if (got.left_drive !== want.left_drive) note_mismatch("left_drive", want, got);
        if (got.position !== want.position) note_mismatch("position", want, got);
        if (got.line_seen !== want.line_seen) note_mismatch("line_seen", want, got);
        if (got.stop !== want.stop) note_mismatch("stop", want, got);
      end
    end
  end

  // --------------------------------------------------------------------------
  // sample side and register writes
  // --------------------------------------------------------------------------

  // valid is only dropped when a gap is drawn, so back-to-back words keep it high
  task automatic send_sample(input logic [9:0] smp);
    int gap;
    gap = draw_wait(src_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(TDATA_W - SAMPLE_BITS){1'b0}}, smp};
    do @(posedge clk); while (!s_tready);
    track_sample(smp);
  endtask

  task automatic send_scan(input logic [SENSORS-1:0] on_mask, input logic [9:0] on_val,
                           input logic [9:0] off_val);
    for (int i = 0; i < SENSORS; i++)
      send_sample(on_mask[i] ? on_val : off_val);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [9:0] val);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    apply_reg(idx, val);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // let the block finish every owed update and go quiet
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (SCAN_END_WAIT) @(posedge clk);
  endtask

  task automatic set_idling(input int src_max, input int sink_max);
    src_gap_max    = src_max;
    sink_stall_max = sink_max;
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // reset values: lost line, full line and the threshold boundary
  task automatic test_default_loop();
    set_idling(MAX_WAIT, MAX_WAIT);
    send_scan(MASK_NONE, 10'd0, SAMPLE_MAX);
    send_scan(MASK_ALL, 10'd0, SAMPLE_MAX);
    send_scan(13'h0008, 10'd499, 10'd500);
    drain();
  endtask

  // centroid at both ends of the array, truncation of an uneven centroid,
  // a threshold of zero and the unmapped register index
  task automatic test_centroid_extremes();
    set_idling(MAX_WAIT, 0);
    write_reg(REG_THRESHOLD, SAMPLE_MAX);
    write_reg(REG_GAIN_P, 10'd255);
    write_reg(REG_GAIN_D, 10'd255);
    write_reg(REG_BASE_SPEED, 10'd1023);
    write_reg(REG_EXIT_MODE, EXIT_EITHER);
    write_reg(REG_SETTLE_SCANS, 10'd1023);   // scan count never gets past this
    write_reg(REG_UNUSED, 10'h3FF);
    send_scan(MASK_FIRST, 10'd1022, SAMPLE_MAX);
    send_scan(MASK_LAST, 10'd1022, SAMPLE_MAX);
    send_scan(13'h0016, 10'd0, SAMPLE_MAX);  // sensors 1, 2, 4
    drain();
    write_reg(REG_THRESHOLD, 10'd0);
    send_scan(MASK_ALL, 10'd0, 10'd0);
    drain();
  endtask

  // wind the integral up hard one way, stop to clear it, then the other way
  task automatic test_drive_saturation();
    set_idling(0, 0);
    write_reg(REG_THRESHOLD, SAMPLE_MAX);
    write_reg(REG_GAIN_I, 10'd255);
    write_reg(REG_BASE_SPEED, 10'd1023);
    for (int n = 0; n < 22; n++) send_scan(MASK_FIRST, 10'd0, SAMPLE_MAX);
    drain();
    write_reg(REG_SETTLE_SCANS, 10'd0);
    send_scan(MASK_FIRST, 10'd0, SAMPLE_MAX);
    drain();
    write_reg(REG_SETTLE_SCANS, 10'd1023);
    write_reg(REG_BASE_SPEED, 10'd0);
    for (int n = 0; n < 30; n++) send_scan(MASK_LAST, 10'd0, SAMPLE_MAX);
    drain();
  endtask

  // both exit modes around the settle count
  task automatic test_exit_conditions();
    set_idling(MAX_WAIT, MAX_WAIT);
    write_reg(REG_GAIN_P, 10'd20);
    write_reg(REG_GAIN_D, 10'd10);
    write_reg(REG_GAIN_I, 10'd0);
    write_reg(REG_THRESHOLD, 10'd500);
    write_reg(REG_EXIT_MODE, EXIT_BOTH);
    write_reg(REG_SETTLE_SCANS, 10'd0);
    send_scan(MASK_EDGES, 10'd0, SAMPLE_MAX);
    send_scan(MASK_EDGES, 10'd0, SAMPLE_MAX);   // count cleared, no stop yet
    send_scan(MASK_FIRST, 10'd0, SAMPLE_MAX);   // one edge is not enough here
    send_scan(MASK_EDGES, 10'd0, SAMPLE_MAX);
    drain();
    write_reg(REG_EXIT_MODE, EXIT_EITHER);
    send_scan(MASK_LAST, 10'd0, SAMPLE_MAX);
    send_scan(MASK_LAST, 10'd0, SAMPLE_MAX);
    drain();
    write_reg(REG_SETTLE_SCANS, 10'd2);
    for (int n = 0; n < 5; n++) send_scan(MASK_EDGES, 10'd0, SAMPLE_MAX);
    drain();
  endtask

  function automatic logic [9:0] pick_reg_value(int hi);
    case ($urandom_range(9, 0))
      0:       return 10'd0;
      1:       return hi[9:0];
      default: return $urandom_range(1023, 0);  // upper bits exercise masking
    endcase
  endfunction

  task automatic randomise_config();
    logic [9:0] settle_val;
    case ($urandom_range(7, 0))
      0:       settle_val = 10'd1023;
      1:       settle_val = $urandom_range(1023, 0);
      default: settle_val = $urandom_range(6, 0);
    endcase
    write_reg(REG_THRESHOLD, pick_reg_value(1023));
    write_reg(REG_GAIN_P, pick_reg_value(255));
    write_reg(REG_GAIN_D, pick_reg_value(255));
    write_reg(REG_GAIN_I, pick_reg_value(255));
    write_reg(REG_BASE_SPEED, pick_reg_value(1023));
    write_reg(REG_EXIT_MODE, $urandom_range(1, 0) ? EXIT_EITHER : EXIT_BOTH);
    write_reg(REG_SETTLE_SCANS, settle_val);
  endtask

  // mostly a band of sensors on the line, with noise and odd patterns mixed in
  task automatic send_random_scan();
    logic [SENSORS-1:0] mask;
    logic [9:0]         on_val, off_val;
    int                 kind, centre, width;
    kind = $urandom_range(9, 0);
    mask = '0;
    if (kind == 0) begin
      for (int i = 0; i < SENSORS; i++) send_sample($urandom_range(1023, 0));
      return;
    end
    if (kind == 1) begin
      mask = $urandom_range(2 ** SENSORS - 1, 0);
    end else if (kind == 2) begin
      mask = MASK_EDGES | SENSORS'($urandom_range(2 ** SENSORS - 1, 0));
    end else if (kind != 3) begin
      centre = $urandom_range(SENSORS - 1, 0);
      width  = $urandom_range(4, 1);
      for (int i = 0; i < SENSORS; i++)
        if (i >= centre - width / 2 && i < centre - width / 2 + width) mask[i] = 1'b1;
    end
    for (int i = 0; i < SENSORS; i++) begin
      on_val  = (thr == 0) ? 10'd0 : 10'($urandom_range(thr - 1, 0));
      off_val = $urandom_range(1023, thr);
      send_sample(mask[i] ? on_val : off_val);
    end
  endtask

  task automatic test_random_loop();
    for (int phase = 0; phase < 8; phase++) begin
      randomise_config();
      case ($urandom_range(3, 0))
        0:       set_idling(0, 0);
        1:       set_idling(MAX_WAIT, 0);
        2:       set_idling(0, MAX_WAIT);
        default: set_idling(MAX_WAIT, MAX_WAIT);
      endcase
      for (int n = 0; n < 5; n++) send_random_scan();
      drain();
    end
  endtask

  initial begin
    reset_model();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_loop();
    test_centroid_extremes();
    test_drive_saturation();
    test_exit_conditions();
    test_random_loop();

    if (pending_drives.size() != 0) begin
      mismatch_count += 1;
      $display("%0d drive updates never arrived", pending_drives.size());
    end
    if (mismatch_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // several times the slowest legal run
  initial begin
    #2000000;
    $display("timeout with %0d updates outstanding", pending_drives.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

[files.f]
hw/rtl/lfpd_pkg.sv
hw/rtl/lfpd_div.sv
hw/rtl/lfpd_mac.sv
hw/rtl/line_follow_pd_controller.sv
dv/tb_line_follow_pd_controller.sv
